@@ sv/swt_pkg.sv @@
// package for the self-calibrating wave trigger
// holds payload structs, state encoding, constants and the divide-by-5 helper
`timescale 1ns / 1ps
package swt_pkg;

  localparam int DefaultCapacity = 256;
  localparam int MinSamples      = 10;
  localparam int MinThreshold    = 320;
  localparam int MinRearm        = 160;
  localparam int LevelW          = 14;

  localparam logic [2:0] RegCalTime    = 3'd0;
  localparam logic [2:0] RegRefractory = 3'd1;
  localparam logic [2:0] RegBlink      = 3'd2;
  localparam logic [2:0] RegDefThr     = 3'd3;
  localparam logic [2:0] RegDefRearm   = 3'd4;

  typedef struct packed {
    logic [13:0] magnitude;
    logic [31:0] now_ms;
  } swt_sample_t;

  typedef struct packed {
    logic        wave_event;
    logic        led_on;
    logic        calibrating;
    logic        is_armed;
    logic [13:0] trigger_level;
    logic [13:0] rearm_level;
  } swt_result_t;

  typedef struct packed {
    logic ins;
    logic shf;
  } swt_cell_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } swt_div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_PREP, S_DRAIN, S_DIVLO_GO, S_DIVLO_WAIT,
    S_DIVHI_GO, S_DIVHI_WAIT, S_LEV1, S_LEV2, S_LEV3, S_DETECT
  } swt_state_t;

  // floor(x/5) for any 16-bit x via reciprocal multiply
  function automatic logic [15:0] div5(input logic [15:0] x);
    logic [33:0] p;
    p = 34'(x) * 34'd52429;
    return 16'(p >> 18);
  endfunction

endpackage

@@ sv/swt_cell.sv @@
// one cell of the sorted sample chain
// depends on swt_pkg
`timescale 1ns / 1ps
module swt_cell (
  input  logic                   clk,
  input  swt_pkg::swt_cell_ctl_t ctl,
  input  logic [13:0]            v,
  input  logic                   occupied,
  input  logic [13:0]            left_val,
  input  logic                   left_gt,
  input  logic [13:0]            right_val,
  output logic [13:0]            val,
  output logic                   gt
);

  // empty cells act as +infinity
  assign gt = !occupied || (val > v);

  always_ff @(posedge clk) begin
    priority if (ctl.ins && gt) begin
      val <= left_gt ? left_val : v;
    end else if (ctl.shf) begin
      val <= right_val;
    end
  end

endmodule

@@ sv/swt_sorter.sv @@
// insertion sorter built as a row of swt_cell, shifts out toward cell 0
// depends on swt_pkg, swt_cell
`timescale 1ns / 1ps
module swt_sorter #(
  parameter int CAP   = swt_pkg::DefaultCapacity,
  parameter int CNT_W = $clog2(CAP + 1)
) (
  input  logic                   clk,
  input  swt_pkg::swt_cell_ctl_t ctl,
  input  logic [13:0]            v,
  input  logic [CNT_W-1:0]       count,
  output logic [13:0]            head
);

  logic [13:0] vals [CAP];
  logic        gts  [CAP];

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [13:0] lv, rv;
    logic        lg;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lg = gts[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign rv = '0;
    end else begin : g_next
      assign rv = vals[i+1];
    end
    swt_cell u_cell (
      .clk(clk), .ctl(ctl), .v(v), .occupied(CNT_W'(i) < count),
      .left_val(lv), .left_gt(lg), .right_val(rv), .val(vals[i]), .gt(gts[i])
    );
  end

  assign head = vals[0];

endmodule

@@ sv/swt_divider.sv @@
// restoring divider, one quotient bit per cycle
// depends on swt_pkg
`timescale 1ns / 1ps
module swt_divider #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DVD_W-1:0]      dividend,
  input  logic [DVS_W-1:0]      divisor,
  output logic [DVD_W-1:0]      quotient,
  output swt_pkg::swt_div_stat_t stat
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [DVS_W:0]   sh;
  logic             fits;
  logic             done;

  assign sh   = {rem, quotient[DVD_W-1]};
  assign fits = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt      <= CW'(DVD_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (cnt != '0) begin
        rem      <= fits ? DVS_W'(sh - {1'b0, dvs}) : DVS_W'(sh);
        quotient <= {quotient[DVD_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end

  assign stat = '{busy: (cnt != '0), done: done};

endmodule

@@ sv/self_calibrating_wave_trigger.sv @@
// self-calibrating wave trigger: hysteresis detector with percentile-derived levels
// ordinary beat: accepted in idle, then the step and detect states; detect holds while a stalled result is pending
// calibration-ending beat: prep, drain, the low and high serial divides and the level states run before detect,
// so its length is set by the shift-out of the sorted cell chain and the serial divider
// one sample in flight at a time; synchronous active-high reset, store needs no clear
`timescale 1ns / 1ps
module self_calibrating_wave_trigger #(
  parameter int SAMPLE_CAPACITY = swt_pkg::DefaultCapacity
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  swt_pkg::swt_sample_t sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output swt_pkg::swt_result_t result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int CNT_W = $clog2(SAMPLE_CAPACITY + 1);
  localparam int SUM_W = 14 + CNT_W;

  // configuration registers
  logic [15:0] cal_time, refr, blink_ms;
  logic [13:0] def_thr, def_rearm;

  // detector state
  swt_pkg::swt_state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic             in_cal, start_cap, armed, blinking;
  logic [31:0]      cal_start, last_ev, blink_start;
  logic [13:0]      thr, hyst;

  // registered beat
  logic [13:0] mag;
  logic [31:0] now;

  // statistics datapath
  logic [CNT_W-1:0] k, n_lo, n_hi, base_idx, hi_start;
  logic [SUM_W-1:0] lo_sum, hi_sum;
  logic [13:0]      base, noise, wave;
  logic [15:0]      t1, w8, h1, thr_raw;

  // sorter and divider hookups
  swt_pkg::swt_cell_ctl_t  cell_ctl;
  logic [13:0]             head;
  logic                    div_start;
  logic [SUM_W-1:0]        div_dvd, div_q;
  logic [CNT_W-1:0]        div_dvs;
  swt_pkg::swt_div_stat_t  div_stat;

  swt_sorter #(.CAP(SAMPLE_CAPACITY), .CNT_W(CNT_W)) u_sorter (
    .clk(clk), .ctl(cell_ctl), .v(mag), .count(count), .head(head)
  );

  swt_divider #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .quotient(div_q), .stat(div_stat)
  );

  // calibration step decisions
  logic [31:0]      start_use;
  logic             ends, has_room;
  logic [CNT_W:0]   count_after;
  assign start_use   = start_cap ? cal_start : now;
  assign ends        = (now - start_use) >= {16'd0, cal_time};
  assign has_room    = count < CNT_W'(SAMPLE_CAPACITY);
  assign count_after = (CNT_W+1)'(count) + (CNT_W+1)'(has_room);

  // detection and blink update, evaluated in the detect state
  logic        ev, armed_next, blink_next;
  always_comb begin
    ev         = 1'b0;
    armed_next = armed;
    blink_next = blinking;
    if (!in_cal) begin
      if (armed && mag > thr) begin
        if ((now - last_ev) > {16'd0, refr}) begin
          ev         = 1'b1;
          armed_next = 1'b0;
          blink_next = 1'b1;
        end
      end else if (!armed && mag < hyst) begin
        armed_next = 1'b1;
      end
    end
    if (blink_next && (now - (ev ? now : blink_start)) >= {16'd0, blink_ms}) begin
      blink_next = 1'b0;
    end
  end

  // level derivation pieces
  logic [15:0] a_lo, b_hi, hyst_raw;
  logic [16:0] thr7;
  assign thr7     = 17'(thr_raw) * 17'd7;
  assign a_lo     = swt_pkg::div5(16'(thr_raw << 1));
  assign b_hi     = swt_pkg::div5(16'(thr7 >> 1));
  assign hyst_raw = ((h1 > a_lo) ? h1 : a_lo) < b_hi ? ((h1 > a_lo) ? h1 : a_lo) : b_hi;

  logic [CNT_W+1:0] n3;
  assign n3 = (CNT_W+2)'(count) * (CNT_W+2)'(3);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      swt_pkg::S_IDLE:       if (sample_valid) state_next = swt_pkg::S_STEP;
      swt_pkg::S_STEP: begin
        if (in_cal && ends && count_after >= (CNT_W+1)'(swt_pkg::MinSamples))
          state_next = swt_pkg::S_PREP;
        else
          state_next = swt_pkg::S_DETECT;
      end
      swt_pkg::S_PREP:       state_next = swt_pkg::S_DRAIN;
      swt_pkg::S_DRAIN:      if (k == count - 1'b1) state_next = swt_pkg::S_DIVLO_GO;
      swt_pkg::S_DIVLO_GO:   state_next = swt_pkg::S_DIVLO_WAIT;
      swt_pkg::S_DIVLO_WAIT: if (div_stat.done) state_next = swt_pkg::S_DIVHI_GO;
      swt_pkg::S_DIVHI_GO:   state_next = swt_pkg::S_DIVHI_WAIT;
      swt_pkg::S_DIVHI_WAIT: if (div_stat.done) state_next = swt_pkg::S_LEV1;
      swt_pkg::S_LEV1:       state_next = swt_pkg::S_LEV2;
      swt_pkg::S_LEV2:       state_next = swt_pkg::S_LEV3;
      swt_pkg::S_LEV3:       state_next = swt_pkg::S_DETECT;
      swt_pkg::S_DETECT:     if (!(result_valid && result_stall)) state_next = swt_pkg::S_IDLE;
      default:               state_next = swt_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    sample_stall = 1'b1;
    cell_ctl     = '0;
    div_start    = 1'b0;
    div_dvd      = lo_sum;
    div_dvs      = n_lo;
    unique case (state)
      swt_pkg::S_IDLE:     sample_stall = 1'b0;
      swt_pkg::S_STEP:     cell_ctl.ins = in_cal && has_room;
      swt_pkg::S_DRAIN:    cell_ctl.shf = 1'b1;
      swt_pkg::S_DIVLO_GO: div_start = 1'b1;
      swt_pkg::S_DIVHI_GO: begin
        div_start = 1'b1;
        div_dvd   = hi_sum;
        div_dvs   = n_hi;
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= swt_pkg::S_IDLE;
      cal_time     <= 16'd10000;
      refr         <= 16'd300;
      blink_ms     <= 16'd100;
      def_thr      <= 14'd4800;
      def_rearm    <= 14'd3200;
      thr          <= 14'd4800;
      hyst         <= 14'd3200;
      count        <= '0;
      in_cal       <= 1'b1;
      start_cap    <= 1'b0;
      cal_start    <= '0;
      armed        <= 1'b1;
      last_ev      <= '0;
      blinking     <= 1'b0;
      blink_start  <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      // the detect state reloads the result register itself
      if (result_valid && !result_stall && state != swt_pkg::S_DETECT)
        result_valid <= 1'b0;

      // config beats must only arrive while idle; the block itself does not enforce this
      if (cfg_valid) begin
        unique case (cfg_index)
          swt_pkg::RegCalTime:    cal_time <= cfg_data;
          swt_pkg::RegRefractory: refr     <= cfg_data;
          swt_pkg::RegBlink:      blink_ms <= cfg_data;
          swt_pkg::RegDefThr: begin
            def_thr <= cfg_data[13:0];
            if (in_cal) thr <= cfg_data[13:0];
          end
          swt_pkg::RegDefRearm: begin
            def_rearm <= cfg_data[13:0];
            if (in_cal) hyst <= cfg_data[13:0];
          end
          default: ;
        endcase
      end

      unique case (state)
        swt_pkg::S_IDLE: begin
          mag <= sample.magnitude;
          now <= sample.now_ms;
        end
        swt_pkg::S_STEP: begin
          if (in_cal) begin
            cal_start <= start_use;
            start_cap <= 1'b1;
            if (has_room) count <= count + 1'b1;
            // too few samples: fall back to default levels
            if (ends && count_after < (CNT_W+1)'(swt_pkg::MinSamples)) begin
              thr    <= def_thr;
              hyst   <= def_rearm;
              in_cal <= 1'b0;
            end
          end
        end
        swt_pkg::S_PREP: begin
          k        <= '0;
          lo_sum   <= '0;
          hi_sum   <= '0;
          base_idx <= CNT_W'(n3 >> 2);
          n_lo     <= CNT_W'(swt_pkg::div5(16'(n3 >> 1)));
          n_hi     <= CNT_W'(swt_pkg::div5(16'(count)));
          hi_start <= count - CNT_W'(swt_pkg::div5(16'(count)));
        end
        swt_pkg::S_DRAIN: begin
          // sorted values leave cell 0 in ascending order
          if (k < n_lo) lo_sum <= lo_sum + SUM_W'(head);
          if (k >= hi_start) hi_sum <= hi_sum + SUM_W'(head);
          if (k == base_idx) base <= head;
          k <= k + 1'b1;
        end
        swt_pkg::S_DIVLO_WAIT: if (div_stat.done) noise <= div_q[13:0];
        swt_pkg::S_DIVHI_WAIT: if (div_stat.done) wave <= div_q[13:0];
        swt_pkg::S_LEV1: begin
          t1 <= ({2'b0, base} > {1'b0, noise, 1'b0}) ? {2'b0, base} : {1'b0, noise, 1'b0};
          w8 <= swt_pkg::div5({wave, 2'b00});
          h1 <= 16'(({2'b0, noise} * 16'd3) >> 1);
        end
        swt_pkg::S_LEV2: thr_raw <= (t1 < w8) ? t1 : w8;
        swt_pkg::S_LEV3: begin
          thr    <= (thr_raw < 16'(swt_pkg::MinThreshold)) ?
                    14'(swt_pkg::MinThreshold) : thr_raw[13:0];
          hyst   <= (hyst_raw < 16'(swt_pkg::MinRearm)) ?
                    14'(swt_pkg::MinRearm) : hyst_raw[13:0];
          in_cal <= 1'b0;
        end
        swt_pkg::S_DETECT: begin
          if (!(result_valid && result_stall)) begin
            armed    <= armed_next;
            blinking <= blink_next;
            if (ev) begin
              last_ev     <= now;
              blink_start <= now;
            end
            result_valid         <= 1'b1;
            result.wave_event    <= ev;
            result.led_on        <= blink_next;
            result.calibrating   <= in_cal;
            result.is_armed      <= armed_next;
            result.trigger_level <= thr;
            result.rearm_level   <= hyst;
          end
        end
        default: ;
      endcase
    end
  end

  // calibration ends only from the step or the final level state
  a_cal_end: assert property (@(posedge clk) disable iff (rst)
    $fell(in_cal) |-> ($past(state) == swt_pkg::S_STEP || $past(state) == swt_pkg::S_LEV3))
    else $error("calibration ended from unexpected state");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SAMPLE_CAPACITY))
    else $error("sample count past capacity");

  a_disarm_event: assert property (@(posedge clk) disable iff (rst)
    $fell(armed) |-> (result_valid && result.wave_event))
    else $error("disarm without event beat");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule
